### hw/rtl/chained_buffer_allocator_assert.svh
// Assertion macros used by the checker module of the chained buffer allocator.
`ifndef CHAINED_BUFFER_ALLOCATOR_ASSERT_SVH
`define CHAINED_BUFFER_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define CBA_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("chained_buffer_allocator assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define CBA_ASSERT_NOW(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("chained_buffer_allocator assertion failed");

`endif

### hw/rtl/cba_pkg.sv
package cba_pkg;

    localparam int POOL_DEPTH_DEFAULT = 1024;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int CHUNKS_W    = 11;
    localparam int BYTES_W     = 16;
    localparam int HEAD_W      = 10;
    localparam int INDEX_W     = 10;
    localparam int SUFFIX_W    = 27;
    localparam int TOTAL_W     = 26;

    localparam logic [CFG_INDEX_W-1:0] REG_CHUNKS_IN_POOL = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_BYTES    = 8'd1;

    localparam logic [CHUNKS_W-1:0] CHUNKS_RESET = 11'd1024;
    localparam logic [BYTES_W-1:0]  BYTES_RESET  = 16'd1024;

    localparam logic [SUFFIX_W-1:0] SUFFIX_MAX = {SUFFIX_W{1'b1}};
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = {TOTAL_W{1'b1}};

    typedef enum logic [0:0] {
        ALU_SAT_ADD,
        ALU_WRAP_INC
    } alu_op_t;

    typedef struct packed {
        alu_op_t             op;
        logic [SUFFIX_W-1:0] a;
        logic [SUFFIX_W-1:0] b;
    } alu_req_t;

endpackage

### hw/rtl/cba_ram.sv
module cba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/cba_alu.sv
module cba_alu (
    input  cba_pkg::alu_req_t             req,
    output logic [cba_pkg::SUFFIX_W-1:0]  result
);

    localparam int SW = cba_pkg::SUFFIX_W;

    logic [SW:0]   sum;
    logic [SW-1:0] inc;

    always_comb begin
        sum = {1'b0, req.a} + {1'b0, req.b};
        inc = req.a + 1'b1;
        unique case (req.op)
            cba_pkg::ALU_SAT_ADD: begin
                result = sum[SW] ? cba_pkg::SUFFIX_MAX : sum[SW-1:0];
            end
            cba_pkg::ALU_WRAP_INC: begin
                result = (inc >= req.b) ? '0 : inc;
            end
            default: begin
                result = '0;
            end
        endcase
    end

endmodule

### hw/rtl/chained_buffer_allocator.sv
// Chained buffer allocator: a pool of equal chunks kept in one single-port-read RAM, each entry
// holding a used flag, a successor link and a byte count. One transaction is taken at a time;
// every RAM access is a read state (address) then an examine state (registered data): an
// allocate repeats this per chunk examined by the round-robin search and per chunk on the
// chain being extended, a release per chunk freed, plus acceptance and result hand-off.
// After reset and after every write to REG_CHUNKS_IN_POOL or REG_CHUNK_BYTES the pool is
// re-initialized by a clearing pass over all POOL_DEPTH entries, with s_ready low. The
// result register lets the next transaction start while a result waits on m_ready.
module chained_buffer_allocator #(
    parameter int POOL_DEPTH = cba_pkg::POOL_DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [cba_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cba_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic                                s_has_chain,
    input  logic [cba_pkg::HEAD_W-1:0]          s_chain_head,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [cba_pkg::INDEX_W-1:0]         m_chunk_index,
    output logic                                m_ok,
    output logic [cba_pkg::TOTAL_W-1:0]         m_head_total_bytes
);

    localparam int SW     = cba_pkg::SUFFIX_W;
    localparam int TW     = cba_pkg::TOTAL_W;
    localparam int OW     = cba_pkg::INDEX_W;
    localparam int IDX_W  = $clog2(POOL_DEPTH);
    localparam int LINK_W = IDX_W + 1;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(POOL_DEPTH - 1);

    typedef struct packed {
        logic              used;
        logic [LINK_W-1:0] link;
        logic [SW-1:0]     bytes;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_EX,
        ST_WALK_RD,
        ST_WALK_EX,
        ST_DONE
    } state_t;

    state_t                        state_reg, state_next;
    logic [cba_pkg::CHUNKS_W-1:0]  chunks_reg, chunks_next;
    logic [cba_pkg::BYTES_W-1:0]   bytes_reg, bytes_next;
    logic [LINK_W-1:0]             cursor_reg, cursor_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [LINK_W-1:0]             steps_reg, steps_next;
    logic                          mode_reg, mode_next;
    logic                          chain_reg, chain_next;
    logic [IDX_W-1:0]              head_reg, head_next;
    logic [IDX_W-1:0]              found_reg, found_next;
    logic [SW-1:0]                 add_reg, add_next;
    logic [SW-1:0]                 total_reg, total_next;
    logic                          res_ok_reg, res_ok_next;
    logic                          m_valid_reg, m_valid_next;
    logic [OW-1:0]                 m_index_reg, m_index_next;
    logic                          m_ok_reg, m_ok_next;
    logic [TW-1:0]                 m_total_reg, m_total_next;

    logic [LINK_W-1:0]    count;
    logic                 ram_wr_en;
    logic [IDX_W-1:0]     ram_wr_addr;
    entry_t               ram_wr_entry;
    logic                 ram_rd_en;
    logic [ENTRY_W-1:0]   ram_rd_data;
    entry_t               rd_entry;
    entry_t               clear_entry;
    cba_pkg::alu_req_t    alu_req;
    logic [SW-1:0]        alu_result;
    logic [LINK_W-1:0]    steps_inc;
    logic                 steps_last;
    logic                 link_null;
    logic                 head_in_range;
    logic [IDX_W-1:0]     search_start;
    logic                 out_free;

    cba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POOL_DEPTH)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    cba_alu u_alu (
        .req    (alu_req),
        .result (alu_result)
    );

    always_comb begin
        if (chunks_reg == '0) begin
            count = LINK_W'(1);
        end else if (32'(chunks_reg) > POOL_DEPTH) begin
            count = LINK_W'(POOL_DEPTH);
        end else begin
            count = LINK_W'(chunks_reg);
        end
    end

    assign rd_entry      = entry_t'(ram_rd_data);
    assign clear_entry   = '{used: 1'b0, link: LINK_NULL, bytes: SW'(bytes_reg)};
    assign steps_inc     = steps_reg + 1'b1;
    assign steps_last    = (steps_inc == count);
    assign link_null     = (rd_entry.link >= count);
    assign head_in_range = (32'(s_chain_head) < 32'(count));
    assign search_start  = (cursor_reg < count) ? cursor_reg[IDX_W-1:0] : '0;
    assign out_free      = !m_valid_reg || m_ready;
    assign ram_rd_en     = (state_reg == ST_SRCH_RD) || (state_reg == ST_WALK_RD);

    always_comb begin
        alu_req.op = cba_pkg::ALU_SAT_ADD;
        alu_req.a  = rd_entry.bytes;
        alu_req.b  = add_reg;
        if (state_reg == ST_SRCH_EX) begin
            alu_req.op = cba_pkg::ALU_WRAP_INC;
            alu_req.a  = SW'(idx_reg);
            alu_req.b  = SW'(count);
        end
    end

    always_comb begin
        state_next   = state_reg;
        chunks_next  = chunks_reg;
        bytes_next   = bytes_reg;
        cursor_next  = cursor_reg;
        idx_next     = idx_reg;
        steps_next   = steps_reg;
        mode_next    = mode_reg;
        chain_next   = chain_reg;
        head_next    = head_reg;
        found_next   = found_reg;
        add_next     = add_reg;
        total_next   = total_reg;
        res_ok_next  = res_ok_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_index_next = m_index_reg;
        m_ok_next    = m_ok_reg;
        m_total_next = m_total_reg;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = idx_reg;
        ram_wr_entry = clear_entry;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_wr_en = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next   = s_mode;
                    chain_next  = s_has_chain && head_in_range;
                    head_next   = IDX_W'(s_chain_head);
                    steps_next  = '0;
                    total_next  = '0;
                    if (s_mode) begin
                        res_ok_next = s_has_chain && head_in_range;
                        idx_next    = IDX_W'(s_chain_head);
                        state_next  = (s_has_chain && head_in_range) ? ST_WALK_RD : ST_DONE;
                    end else begin
                        res_ok_next = 1'b0;
                        idx_next    = search_start;
                        state_next  = ST_SRCH_RD;
                    end
                end
            end
            ST_SRCH_RD: begin
                state_next = ST_SRCH_EX;
            end
            ST_SRCH_EX: begin
                if (!rd_entry.used) begin
                    ram_wr_en    = 1'b1;
                    ram_wr_entry = '{used: 1'b1, link: rd_entry.link, bytes: rd_entry.bytes};
                    found_next   = idx_reg;
                    cursor_next  = LINK_W'(idx_reg) + 1'b1;
                    add_next     = rd_entry.bytes;
                    total_next   = rd_entry.bytes;
                    res_ok_next  = 1'b1;
                    if (chain_reg) begin
                        idx_next   = head_reg;
                        steps_next = '0;
                        state_next = ST_WALK_RD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else if (steps_last) begin
                    cursor_next = '0;
                    res_ok_next = 1'b0;
                    state_next  = ST_DONE;
                end else begin
                    idx_next   = alu_result[IDX_W-1:0];
                    steps_next = steps_inc;
                    state_next = ST_SRCH_RD;
                end
            end
            ST_WALK_RD: begin
                state_next = ST_WALK_EX;
            end
            ST_WALK_EX: begin
                ram_wr_en = 1'b1;
                if (!mode_reg) begin
                    ram_wr_entry.used  = rd_entry.used;
                    ram_wr_entry.bytes = alu_result;
                    if (link_null && (idx_reg != found_reg)) begin
                        ram_wr_entry.link = LINK_W'(found_reg);
                    end else begin
                        ram_wr_entry.link = rd_entry.link;
                    end
                    if (idx_reg == head_reg) begin
                        total_next = alu_result;
                    end
                end
                if (link_null || steps_last) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next   = rd_entry.link[IDX_W-1:0];
                    steps_next = steps_inc;
                    state_next = ST_WALK_RD;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = res_ok_reg;
                    if (res_ok_reg && !mode_reg) begin
                        m_index_next = OW'(found_reg);
                        m_total_next = (total_reg > SW'(cba_pkg::TOTAL_MAX)) ?
                                       cba_pkg::TOTAL_MAX : total_reg[TW-1:0];
                    end else begin
                        m_index_next = '0;
                        m_total_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase

        if (cfg_wr_en) begin
            unique case (cfg_index)
                cba_pkg::REG_CHUNKS_IN_POOL: begin
                    chunks_next = cfg_data[cba_pkg::CHUNKS_W-1:0];
                    state_next  = ST_CLEAR;
                    idx_next    = '0;
                    cursor_next = '0;
                end
                cba_pkg::REG_CHUNK_BYTES: begin
                    bytes_next  = cfg_data[cba_pkg::BYTES_W-1:0];
                    state_next  = ST_CLEAR;
                    idx_next    = '0;
                    cursor_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            chunks_reg  <= cba_pkg::CHUNKS_RESET;
            bytes_reg   <= cba_pkg::BYTES_RESET;
            cursor_reg  <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            chunks_reg  <= chunks_next;
            bytes_reg   <= bytes_next;
            cursor_reg  <= cursor_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
        steps_reg   <= steps_next;
        mode_reg    <= mode_next;
        chain_reg   <= chain_next;
        head_reg    <= head_next;
        found_reg   <= found_next;
        add_reg     <= add_next;
        total_reg   <= total_next;
        res_ok_reg  <= res_ok_next;
        m_index_reg <= m_index_next;
        m_ok_reg    <= m_ok_next;
        m_total_reg <= m_total_next;
    end

    assign s_ready            = (state_reg == ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_chunk_index      = m_index_reg;
    assign m_ok               = m_ok_reg;
    assign m_head_total_bytes = m_total_reg;

endmodule

### hw/rtl/cba_checker.sv
`include "chained_buffer_allocator_assert.svh"

module cba_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             cfg_wr_en,
    input logic [cba_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [cba_pkg::INDEX_W-1:0]      m_chunk_index,
    input logic                             m_ok,
    input logic [cba_pkg::TOTAL_W-1:0]      m_head_total_bytes
);

    // A stalled result transaction keeps its contents.
    `CBA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_chunk_index) && $stable(m_ok) && $stable(m_head_total_bytes))

    // A failed request reports zero in every other field.
    `CBA_ASSERT_NOW(a_fail_zero, aclk, aresetn, m_valid && !m_ok, (m_chunk_index == '0) && (m_head_total_bytes == '0))

    // The block works on one transaction at a time.
    `CBA_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)

    // A write to REG_CHUNKS_IN_POOL or REG_CHUNK_BYTES starts the pool re-initialization.
    `CBA_ASSERT_NEXT(a_cfg_reinit, aclk, aresetn, cfg_wr_en && ((cfg_index == cba_pkg::REG_CHUNKS_IN_POOL) || (cfg_index == cba_pkg::REG_CHUNK_BYTES)), !s_ready)

endmodule

bind chained_buffer_allocator cba_checker u_cba_checker (.*);

### test/cba_tb_pkg.sv
`timescale 1ns / 1ps

package cba_tb_pkg;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

endpackage

### test/allocation_checker.sv
`timescale 1ns / 1ps

module allocation_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [cba_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cba_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_mode,
    input  logic                            s_has_chain,
    input  logic [cba_pkg::HEAD_W-1:0]      s_chain_head,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [cba_pkg::INDEX_W-1:0]     m_chunk_index,
    input  logic                            m_ok,
    input  logic [cba_pkg::TOTAL_W-1:0]     m_head_total_bytes,
    output int                              fail_count,
    output int                              grants_pending
);
    import cba_pkg::*;
    import cba_tb_pkg::*;

    localparam int DEPTH       = POOL_DEPTH_DEFAULT;
    localparam int NULL_LINK   = POOL_DEPTH_DEFAULT;
    localparam int SUFFIX_CAP  = int'(SUFFIX_MAX);
    localparam int TOTAL_CAP   = int'(TOTAL_MAX);

    typedef struct packed {
        logic [INDEX_W-1:0] chunk_index;
        logic               ok;
        logic [TOTAL_W-1:0] head_total;
    } grant_t;

    logic                in_use      [DEPTH];
    int                  link        [DEPTH];
    int                  chain_bytes [DEPTH];
    int                  cursor;
    logic [CHUNKS_W-1:0] cfg_chunks;
    logic [BYTES_W-1:0]  cfg_bytes;
    grant_t              grants_due  [$];
    int                  grant_seq;

    function automatic int pool_size();
        if (cfg_chunks == 0) return 1;
        if (cfg_chunks > DEPTH) return DEPTH;
        return int'(cfg_chunks);
    endfunction

    function automatic void reinit_pool();
        for (int i = 0; i < DEPTH; i++) begin
            in_use[i]      = 1'b0;
            link[i]        = NULL_LINK;
            chain_bytes[i] = int'(cfg_bytes);
        end
        cursor = 0;
    endfunction

    function automatic grant_t predict_grant(input logic mode, input logic has_chain,
                                             input logic [HEAD_W-1:0] head);
        grant_t g;
        int     n;
        int     idx;
        int     nx;
        int     step;
        int     start;
        int     found;
        int     tail;
        int     add;
        int     sum;
        int     total;
        bit     at_tail;
        n = pool_size();
        g = '0;
        if (mode == MODE_RELEASE) begin
            if (!has_chain || head >= n) return g;
            idx = int'(head);
            for (step = 0; step < n; step++) begin
                nx = link[idx];
                in_use[idx]      = 1'b0;
                link[idx]        = NULL_LINK;
                chain_bytes[idx] = int'(cfg_bytes);
                if (nx >= n) break;
                idx = nx;
            end
            g.ok = 1'b1;
            return g;
        end
        start = (cursor < n) ? cursor : 0;
        found = n;
        for (step = 0; step < n; step++) begin
            idx = start + step;
            if (idx >= n) idx -= n;
            if (!in_use[idx]) begin
                found = idx;
                break;
            end
        end
        if (found >= n) begin
            cursor = 0;
            return g;
        end
        in_use[found] = 1'b1;
        cursor = found + 1;
        total = chain_bytes[found];
        if (has_chain && head < n) begin
            add = chain_bytes[found];
            idx = int'(head);
            at_tail = 1'b0;
            tail = 0;
            for (step = 0; step < n; step++) begin
                sum = chain_bytes[idx] + add;
                chain_bytes[idx] = (sum > SUFFIX_CAP) ? SUFFIX_CAP : sum;
                nx = link[idx];
                if (nx >= n) begin
                    at_tail = 1'b1;
                    tail = idx;
                    break;
                end
                idx = nx;
            end
            if (at_tail && tail != found) link[tail] = found;
            total = chain_bytes[int'(head)];
        end
        g.chunk_index = INDEX_W'(found);
        g.ok          = 1'b1;
        g.head_total  = TOTAL_W'((total > TOTAL_CAP) ? TOTAL_CAP : total);
        return g;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        if (fail_count < 40) begin
            $display("[%0t] transaction %0d: %s expected %0d, got %0d",
                     $time, grant_seq, what, want, got);
        end
        fail_count++;
    endtask

    always @(posedge aclk) begin
        grant_t want;
        if (!aresetn) begin
            cfg_chunks = CHUNKS_RESET;
            cfg_bytes  = BYTES_RESET;
            reinit_pool();
            grants_due.delete();
            grant_seq  = 0;
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_CHUNKS_IN_POOL) begin
                    cfg_chunks = cfg_data[CHUNKS_W-1:0];
                    reinit_pool();
                end else if (cfg_index == REG_CHUNK_BYTES) begin
                    cfg_bytes = cfg_data[BYTES_W-1:0];
                    reinit_pool();
                end
            end
            if (m_valid && m_ready) begin
                if (grants_due.size() == 0) begin
                    report_mismatch("result with nothing outstanding, chunk_index",
                                    -1, longint'(m_chunk_index));
                end else begin
                    want = grants_due.pop_front();
                    if (m_chunk_index !== want.chunk_index)
                        report_mismatch("chunk_index", longint'(want.chunk_index),
                                        longint'(m_chunk_index));
                    if (m_ok !== want.ok)
                        report_mismatch("ok", longint'(want.ok), longint'(m_ok));
                    if (m_head_total_bytes !== want.head_total)
                        report_mismatch("head_total_bytes", longint'(want.head_total),
                                        longint'(m_head_total_bytes));
                end
                grant_seq++;
            end
            if (s_valid && s_ready)
                grants_due.push_back(predict_grant(s_mode, s_has_chain, s_chain_head));
        end
        grants_pending <= grants_due.size();
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cba_pkg::*;
    import cba_tb_pkg::*;

    localparam int QUIET_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 1650;

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic                   s_mode       = 1'b0;
    logic                   s_has_chain  = 1'b0;
    logic [HEAD_W-1:0]      s_chain_head = '0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic [INDEX_W-1:0]     m_chunk_index;
    logic                   m_ok;
    logic [TOTAL_W-1:0]     m_head_total_bytes;

    int                     fail_count;
    int                     grants_pending;
    int                     s_idle_pct   = 36;
    int                     m_idle_pct   = 36;
    int                     quiet_cycles = 0;
    logic                   opens_chain_q [$];
    logic [HEAD_W-1:0]      live_heads    [$];

    chained_buffer_allocator u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_has_chain        (s_has_chain),
        .s_chain_head       (s_chain_head),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_chunk_index      (m_chunk_index),
        .m_ok               (m_ok),
        .m_head_total_bytes (m_head_total_bytes)
    );

    allocation_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_has_chain        (s_has_chain),
        .s_chain_head       (s_chain_head),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_chunk_index      (m_chunk_index),
        .m_ok               (m_ok),
        .m_head_total_bytes (m_head_total_bytes),
        .fail_count         (fail_count),
        .grants_pending     (grants_pending)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= m_idle_pct);
    end

    // Heads of chains opened by plain allocations are kept for later appends and releases.
    always @(posedge aclk) begin
        if (m_valid && m_ready && opens_chain_q.size() != 0) begin
            if (opens_chain_q.pop_front() && m_ok) live_heads.push_back(m_chunk_index);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("chained_buffer_allocator verification failed");
            $finish;
        end
    end

    task automatic send_item(input logic mode, input logic has_chain,
                             input logic [HEAD_W-1:0] head);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_has_chain  <= has_chain;
        s_chain_head <= head;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        opens_chain_q.push_back(mode == MODE_ALLOC && !has_chain);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        s_valid <= 1'b0;
        repeat (4) @(posedge aclk);
        while (grants_pending != 0) @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        live_heads.delete();
    endtask

    initial begin
        int                  phase;
        int                  n_items;
        int                  item;
        int                  pick;
        int                  slot;
        int                  span;
        int                  random_sent;
        logic [CHUNKS_W-1:0] chunks;
        logic [BYTES_W-1:0]  chunk_size;
        logic [HEAD_W-1:0]   head;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(MODE_RELEASE, 1'b0, 10'd1023);
        send_item(MODE_ALLOC, 1'b0, 10'd1023);
        send_item(MODE_ALLOC, 1'b1, 10'd0);
        send_item(MODE_RELEASE, 1'b1, 10'd0);
        send_item(MODE_ALLOC, 1'b1, 10'd1023);

        // A zero pool size is treated as a single chunk.
        write_reg(REG_CHUNKS_IN_POOL, 16'hA800);
        send_item(MODE_ALLOC, 1'b0, 10'd0);
        send_item(MODE_ALLOC, 1'b0, 10'd0);
        send_item(MODE_RELEASE, 1'b1, 10'd5);
        send_item(MODE_ALLOC, 1'b1, 10'd3);
        send_item(MODE_RELEASE, 1'b1, 10'd0);
        send_item(MODE_ALLOC, 1'b1, 10'd1);

        // A two-chunk loop is built first, so every later append goes round it, one step per
        // pool chunk, and drives the byte counts into saturation.
        write_reg(REG_CHUNKS_IN_POOL, 16'hFFFF);
        write_reg(REG_CHUNK_BYTES, 16'hFFFF);
        send_item(MODE_ALLOC, 1'b1, 10'd1);
        send_item(MODE_ALLOC, 1'b1, 10'd0);
        repeat (5) send_item(MODE_ALLOC, 1'b1, 10'd0);
        send_item(MODE_RELEASE, 1'b1, 10'd2);
        send_item(MODE_RELEASE, 1'b1, 10'd0);

        random_sent = 0;
        for (phase = 0; random_sent < RANDOM_ITEMS; phase++) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                chunks = CHUNKS_W'($urandom_range(40, 2));
            end else if (pick < 70) begin
                chunks = CHUNKS_W'($urandom_range(1024, 41));
            end else if (pick < 80) begin
                chunks = '0;
            end else if (pick < 90) begin
                chunks = 11'd1;
            end else begin
                chunks = CHUNKS_W'($urandom_range(2047, 1025));
            end
            pick = $urandom_range(99);
            if (phase == 0 || pick < 25) begin
                chunk_size = '0;
            end else if (pick < 50) begin
                chunk_size = '1;
            end else begin
                chunk_size = BYTES_W'($urandom);
            end
            write_reg(REG_CHUNKS_IN_POOL, {5'($urandom), chunks});
            write_reg(REG_CHUNK_BYTES, chunk_size);

            s_idle_pct = (phase == 1) ? 0 : 36;
            m_idle_pct = (phase == 1) ? 0 : 36;
            span = (chunks == 0) ? 1 : (chunks > 1024) ? 1024 : int'(chunks);
            span = (span + 1 > 1023) ? 1023 : span + 1;
            n_items = $urandom_range(160, 60);

            for (item = 0; item < n_items; item++) begin
                pick = $urandom_range(99);
                head = HEAD_W'($urandom);
                if (pick < 12) begin
                    send_item(1'($urandom_range(1)), 1'($urandom_range(1)), head);
                end else if (pick < 22) begin
                    head = HEAD_W'($urandom_range(span));
                    send_item(1'($urandom_range(1)), 1'b1, head);
                end else if (pick < 50 || live_heads.size() == 0) begin
                    send_item(MODE_ALLOC, 1'b0, head);
                end else if (pick < 78) begin
                    head = live_heads[$urandom_range(live_heads.size() - 1)];
                    send_item(MODE_ALLOC, 1'b1, head);
                end else begin
                    slot = $urandom_range(live_heads.size() - 1);
                    head = live_heads[slot];
                    live_heads.delete(slot);
                    send_item(MODE_RELEASE, 1'b1, head);
                end
                random_sent++;
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (grants_pending != 0) @(posedge aclk);
        repeat (32) @(posedge aclk);
        if (fail_count == 0) begin
            $display("chained_buffer_allocator verification clean");
        end else begin
            $display("chained_buffer_allocator verification failed");
        end
        $finish;
    end

endmodule
